FILE: rtl/aes_pkg.sv
// ----------------------------------------------------------------------------
// aes_pkg
// Shared types, constants and byte functions for the AES-256 cipher unit.
// ----------------------------------------------------------------------------
package aes_pkg;

	localparam int NumKeyRegs = 4;
	localparam int NumWords   = 60;
	localparam int NumRounds  = 14;

	localparam logic [1:0] KeyReg0 = 2'd0;
	localparam logic [1:0] KeyReg1 = 2'd1;
	localparam logic [1:0] KeyReg2 = 2'd2;
	localparam logic [1:0] KeyReg3 = 2'd3;

	localparam logic OpEncrypt = 1'b0;
	localparam logic OpDecrypt = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXPAND,
		ST_INIT,
		ST_ROUND,
		ST_DONE
	} ctl_state_t;

	// controller to datapath
	typedef struct packed {
		logic       capture;     // take block and operation from the ports
		logic       load_key;    // load words 0..7 from key registers
		logic       expand_step; // compute one schedule word
		logic       load_block;  // initial key add on the captured block
		logic       round_step;  // run one round
		logic       last_round;  // final round has no mix
		logic [3:0] rnd;         // round index for key fetch
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic expand_done;
	} dp_stat_t;

	function automatic logic [7:0] sbox_fwd(input logic [7:0] v);
		logic [7:0] t [256];
		t = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
		return t[v];
	endfunction

	function automatic logic [7:0] sbox_inv(input logic [7:0] v);
		logic [7:0] t [256];
		t = '{
		8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
		8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
		8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
		8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
		8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
		8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
		8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
		8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
		8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
		8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
		8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
		8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
		8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
		8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
		8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
		8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
		return t[v];
	endfunction

	function automatic logic [7:0] xtime(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [31:0] mix_col(input logic [31:0] c);
		logic [7:0] a0, a1, a2, a3;
		a0 = c[31:24]; a1 = c[23:16]; a2 = c[15:8]; a3 = c[7:0];
		return {xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3,
			a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3,
			a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3,
			xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3)};
	endfunction

	// inverse mix as a pre-step {4,5} times 4 followed by the forward mix
	function automatic logic [31:0] inv_mix_col(input logic [31:0] c);
		logic [7:0] a0, a1, a2, a3, u, v;
		a0 = c[31:24]; a1 = c[23:16]; a2 = c[15:8]; a3 = c[7:0];
		u = xtime(xtime(a0 ^ a2));
		v = xtime(xtime(a1 ^ a3));
		return mix_col({a0 ^ u, a1 ^ v, a2 ^ u, a3 ^ v});
	endfunction

	function automatic logic [31:0] sub_word(input logic [31:0] w);
		return {sbox_fwd(w[31:24]), sbox_fwd(w[23:16]), sbox_fwd(w[15:8]), sbox_fwd(w[7:0])};
	endfunction

endpackage

FILE: rtl/aes_ram.sv
// ----------------------------------------------------------------------------
// aes_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module aes_ram #(
	parameter int Width = 32,
	parameter int Depth = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

FILE: rtl/aes_dp.sv
// ----------------------------------------------------------------------------
// aes_dp
// Datapath: key schedule into the round-key RAM, state register, one round
// per cycle. Round keys are read as a 128-bit row from four word RAMs.
// ----------------------------------------------------------------------------
module aes_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  aes_pkg::dp_cmd_t  cmd,
	output aes_pkg::dp_stat_t stat,
	input  logic [63:0]       key0,
	input  logic [63:0]       key1,
	input  logic [63:0]       key2,
	input  logic [63:0]       key3,
	input  logic              operation,
	input  logic [63:0]       block_high,
	input  logic [63:0]       block_low,
	output logic [127:0]      state
);
	import aes_pkg::*;

	// schedule: window of the last eight words
	logic [31:0] win_q [8];
	logic [6:0]  widx_q;     // next word index to produce
	logic [7:0]  rcon_q;
	logic [31:0] tmp, new_w, rot;
	logic        we;
	logic [3:0]  waddr;
	logic [31:0] wdata;
	logic [1:0]  wcol;

	// store: 4 RAMs (one per column), 16 rows deep, rows 0..14 hold round keys
	logic [31:0] rk_rd [4];
	logic [127:0] rk;
	logic [3:0]  raddr;

	logic [127:0] state_q;
	logic         dec_q;
	logic [127:0] ss, mixed, nxt;
	logic [127:0] blk;

	always_comb begin
		rot = {win_q[7][23:0], win_q[7][31:24]};
		if (widx_q[2:0] == 3'd0) begin
			tmp = sub_word(rot) ^ {rcon_q, 24'h0};
		end else if (widx_q[2:0] == 3'd4) begin
			tmp = sub_word(win_q[7]);
		end else begin
			tmp = win_q[7];
		end
		new_w = win_q[0] ^ tmp;
	end

	// keep stepping eight past word 59 so words 52..59 drain out of the window
	assign stat.expand_done = (widx_q == 7'(NumWords + 8));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			widx_q <= '0;
			rcon_q <= 8'h01;
		end else if (cmd.load_key) begin
			widx_q <= 7'd8;
			rcon_q <= 8'h01;
		end else if (cmd.expand_step && !stat.expand_done) begin
			widx_q <= widx_q + 7'd1;
			if (widx_q[2:0] == 3'd0) begin
				rcon_q <= xtime(rcon_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_key) begin
			win_q[0] <= key0[63:32]; win_q[1] <= key0[31:0];
			win_q[2] <= key1[63:32]; win_q[3] <= key1[31:0];
			win_q[4] <= key2[63:32]; win_q[5] <= key2[31:0];
			win_q[6] <= key3[63:32]; win_q[7] <= key3[31:0];
		end else if (cmd.expand_step && !stat.expand_done) begin
			for (int i = 0; i < 7; i++) begin
				win_q[i] <= win_q[i+1];
			end
			win_q[7] <= new_w;
		end
	end

	// write words 0..7 during expansion too: word widx-8 is leaving the window
	always_comb begin
		we    = cmd.expand_step && (widx_q >= 7'd8) && !stat.expand_done;
		waddr = 4'((widx_q - 7'd8) >> 2);
		wcol  = 2'(widx_q - 7'd8);
		wdata = win_q[0];
	end

	genvar g;
	generate
		for (g = 0; g < 4; g++) begin : g_col
			aes_ram #(.Width(32), .Depth(16)) u_ram (
				.clk   (clk),
				.we    (we && (wcol == 2'(g))),
				.waddr (waddr),
				.wdata (wdata),
				.raddr (raddr),
				.rdata (rk_rd[g])
			);
		end
	endgenerate

	assign rk = {rk_rd[0], rk_rd[1], rk_rd[2], rk_rd[3]};
	assign raddr = cmd.rnd;

	assign blk = {block_high, block_low};

	always_comb begin
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				logic [7:0] v;
				v = dec_q ? state_q[127-8*(4*((c+4-r)%4)+r) -: 8]
					: state_q[127-8*(4*((c+r)%4)+r) -: 8];
				ss[127-8*(4*c+r) -: 8] = dec_q ? sbox_inv(v) : sbox_fwd(v);
			end
		end
		for (int c = 0; c < 4; c++) begin
			mixed[127-32*c -: 32] = dec_q ? inv_mix_col(ss[127-32*c -: 32] ^ rk[127-32*c -: 32])
				: mix_col(ss[127-32*c -: 32]) ^ rk[127-32*c -: 32];
		end
		nxt = cmd.last_round ? (ss ^ rk) : mixed;
	end

	// hold the request from the accepting edge on
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			state_q <= blk;
			dec_q   <= operation;
		end else if (cmd.load_block) begin
			state_q <= state_q ^ rk;
		end else if (cmd.round_step) begin
			state_q <= nxt;
		end
	end

	assign state = state_q;
endmodule

FILE: rtl/aes_ctl.sv
// ----------------------------------------------------------------------------
// aes_ctl
// Controller: key expansion on demand, then initial add and 14 rounds.
// ----------------------------------------------------------------------------
module aes_ctl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              operation,
	input  logic              key_written,
	input  aes_pkg::dp_stat_t stat,
	output aes_pkg::dp_cmd_t  cmd,
	output logic              busy,
	output logic              done
);
	import aes_pkg::*;

	ctl_state_t state_q, state_d;
	logic       expanded_q;
	logic       dec_q;
	logic [3:0] cnt_q, cnt_d;   // rounds done
	logic       load_key;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			expanded_q <= 1'b0;
			dec_q      <= 1'b0;
			cnt_q      <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (state_q == ST_IDLE && start) begin
				dec_q <= operation;
			end
			if (key_written) begin
				expanded_q <= 1'b0;
			end else if (state_q == ST_EXPAND && state_d == ST_INIT) begin
				expanded_q <= 1'b1;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		cmd      = '0;
		busy     = (state_q != ST_IDLE);
		done     = 1'b0;
		load_key = 1'b0;
		case (state_q)
			ST_IDLE: begin
				cnt_d       = '0;
				cmd.capture = start;
				if (start) begin
					if (expanded_q) begin
						state_d = ST_INIT;
					end else begin
						load_key = 1'b1;
						state_d  = ST_EXPAND;
					end
				end
				// fetch initial key row early
				cmd.rnd = operation ? 4'(NumRounds) : 4'd0;
			end
			ST_EXPAND: begin
				cmd.expand_step = 1'b1;
				if (stat.expand_done) begin
					state_d = ST_INIT;
				end
				cmd.rnd = dec_q ? 4'(NumRounds) : 4'd0;
			end
			ST_INIT: begin
				cmd.load_block = 1'b1;
				cmd.rnd = dec_q ? 4'(NumRounds - 1) : 4'd1;
				state_d = ST_ROUND;
			end
			ST_ROUND: begin
				cmd.round_step = 1'b1;
				cmd.last_round = (cnt_q == 4'(NumRounds - 1));
				cnt_d = cnt_q + 4'd1;
				cmd.rnd = dec_q ? 4'(NumRounds - 2) - cnt_q : cnt_q + 4'd2;
				if (cmd.last_round) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				done    = 1'b1;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
		cmd.load_key = load_key;
	end
endmodule

FILE: rtl/aes256_block_cipher_unit.sv
// After start is accepted, the unit runs the initial key add, then the rounds,
// and raises done; when a key register was written since the last block, key
// expansion runs first (the schedule writes one word per cycle).
// A new start is taken only in idle after done: there is a single round unit.
// done is a one-cycle strobe; the receiver cannot stall. Reset clears the
// key registers and control and marks the key unexpanded.
// ----------------------------------------------------------------------------
// aes256_block_cipher_unit
// AES-256 ECB encrypt/decrypt unit with on-demand key expansion.
// ----------------------------------------------------------------------------
module aes256_block_cipher_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        start,
	output logic        busy,
	input  logic        operation,
	input  logic [63:0] block_high,
	input  logic [63:0] block_low,
	output logic        done,
	output logic [63:0] result_high,
	output logic [63:0] result_low
);
	import aes_pkg::*;

	logic [63:0]  key_q [NumKeyRegs];
	dp_cmd_t      cmd;
	dp_stat_t     stat;
	logic [127:0] st;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NumKeyRegs; i++) begin
				key_q[i] <= '0;
			end
		end else if (cfg_we) begin
			case (cfg_index)
				KeyReg0: key_q[0] <= cfg_data;
				KeyReg1: key_q[1] <= cfg_data;
				KeyReg2: key_q[2] <= cfg_data;
				KeyReg3: key_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	aes_ctl u_ctl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.operation   (operation),
		.key_written (cfg_we),
		.stat        (stat),
		.cmd         (cmd),
		.busy        (busy),
		.done        (done)
	);

	aes_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.key0       (key_q[0]),
		.key1       (key_q[1]),
		.key2       (key_q[2]),
		.key3       (key_q[3]),
		.operation  (operation),
		.block_high (block_high),
		.block_low  (block_low),
		.state      (st)
	);

	assign result_high = st[127:64];
	assign result_low  = st[63:0];
endmodule
